@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/core/pdf_pkg.sv @@
package pdf_pkg;

   // Slots are taken from the low bits of the id, so the depth is a power of two.
   localparam int TABLE_ENTRIES = 16384;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int ID_W          = 64;
   localparam int PORT_W        = 16;

   localparam logic [15:0]       ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]        PROTO_UDP      = 8'd17;
   localparam logic [PORT_W-1:0] RESET_PORT     = 16'd34254;

   typedef logic [1:0] reason_type;

   localparam reason_type REASON_UNMATCHED = 2'd0;
   localparam reason_type REASON_ACCEPTED  = 2'd1;
   localparam reason_type REASON_STALE     = 2'd2;

   typedef struct packed {
      logic clear;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ctrl_status_type;

endpackage

@@ rtl/core/pdf_channels.sv @@
interface pdf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             frame_long_enough;
   logic [15:0]                      ether_type;
   logic [7:0]                       ip_protocol;
   logic [15:0]                      udp_dest_port;
   logic signed [pdf_pkg::ID_W-1:0]  msg_id;

   modport source (
      output valid, frame_long_enough, ether_type, ip_protocol, udp_dest_port, msg_id,
      input  ready
   );
   modport sink (
      input  valid, frame_long_enough, ether_type, ip_protocol, udp_dest_port, msg_id,
      output ready
   );
endinterface

interface pdf_rsp_if;
   logic                valid;
   logic                ready;
   logic                drop;
   pdf_pkg::reason_type verdict_reason;

   modport source (output valid, drop, verdict_reason, input ready);
   modport sink (input valid, drop, verdict_reason, output ready);
endinterface

interface pdf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pdf_pkg::PORT_W-1:0]  match_port;

   modport source (output valid, match_port, input ready);
   modport sink (input valid, match_port, output ready);
endinterface

@@ rtl/core/pdf_ctrl.sv @@
`include "assert_macros.svh"

module pdf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pdf_pkg::ctrl_status_type status,
   output pdf_pkg::ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.clear  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // The verdict waits here while the previous one still sits unread.
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_SAME(a_no_accept_while_clearing, clock, reset, state_ff == ST_CLEAR, !cmd.accept)
   `ASSERT_NEXT(a_accept_goes_to_lookup, clock, reset, cmd.accept, state_ff == ST_LOOKUP)
   `ASSERT_NEXT(a_commit_returns_idle, clock, reset, cmd.commit, state_ff == ST_IDLE && req_ready)

endmodule

@@ rtl/core/pdf_datapath.sv @@
module pdf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pdf_pkg::ctrl_cmd_type               cmd,
   output pdf_pkg::ctrl_status_type            status,
   input  logic                                cfg_valid,
   input  logic [pdf_pkg::PORT_W-1:0]          cfg_port,
   input  logic                                frame_long_enough,
   input  logic [15:0]                         ether_type,
   input  logic [7:0]                          ip_protocol,
   input  logic [15:0]                         udp_dest_port,
   input  logic signed [pdf_pkg::ID_W-1:0]     msg_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                drop,
   output pdf_pkg::reason_type                 verdict_reason
);

   logic signed [pdf_pkg::ID_W-1:0] mem [pdf_pkg::TABLE_ENTRIES];

   logic [pdf_pkg::PORT_W-1:0]      match_port_ff;
   logic [pdf_pkg::SLOT_W-1:0]      clr_cnt_ff;
   logic                            zero_seen_ff;
   logic                            matched_ff;
   logic                            is_zero_ff;
   logic signed [pdf_pkg::ID_W-1:0] id_ff;
   logic signed [pdf_pkg::ID_W-1:0] rd_data_ff;
   logic                            rsp_valid_ff;
   logic                            drop_ff;
   pdf_pkg::reason_type             reason_ff;

   logic                            matched_in;
   logic                            drop_in;
   pdf_pkg::reason_type             reason_in;
   logic                            store_new;
   logic                            zero_seen_in;
   logic                            mem_we;
   logic [pdf_pkg::SLOT_W-1:0]      mem_wa;
   logic signed [pdf_pkg::ID_W-1:0] mem_wd;

   assign matched_in = frame_long_enough && (ether_type == pdf_pkg::ETHERTYPE_IPV4) &&
                       (ip_protocol == pdf_pkg::PROTO_UDP) && (udp_dest_port == match_port_ff);

   // Stored ids start at zero and only grow, so a negative id always compares stale.
   always_comb begin
      drop_in      = 1'b0;
      reason_in    = pdf_pkg::REASON_UNMATCHED;
      store_new    = 1'b0;
      zero_seen_in = zero_seen_ff;
      if (matched_ff) begin
         if (is_zero_ff) begin
            if (zero_seen_ff) begin
               drop_in   = 1'b1;
               reason_in = pdf_pkg::REASON_STALE;
            end else begin
               reason_in    = pdf_pkg::REASON_ACCEPTED;
               zero_seen_in = 1'b1;
            end
         end else if (rd_data_ff >= id_ff) begin
            drop_in   = 1'b1;
            reason_in = pdf_pkg::REASON_STALE;
         end else begin
            reason_in = pdf_pkg::REASON_ACCEPTED;
            store_new = 1'b1;
         end
      end
   end

   assign mem_we = cmd.clear || (cmd.commit && store_new);
   assign mem_wa = cmd.clear ? clr_cnt_ff : id_ff[pdf_pkg::SLOT_W-1:0];
   assign mem_wd = cmd.clear ? '0 : id_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[msg_id[pdf_pkg::SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         matched_ff <= matched_in;
         is_zero_ff <= (msg_id == '0);
         id_ff      <= msg_id;
      end
      if (cmd.commit) begin
         drop_ff   <= drop_in;
         reason_ff <= reason_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_port_ff <= pdf_pkg::RESET_PORT;
         clr_cnt_ff    <= '0;
         zero_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cfg_valid) begin
            match_port_ff <= cfg_port;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + pdf_pkg::SLOT_W'(1);
         end
         if (cmd.commit) begin
            zero_seen_ff <= zero_seen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_cnt_ff == pdf_pkg::SLOT_W'(pdf_pkg::TABLE_ENTRIES - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign drop           = drop_ff;
   assign verdict_reason = reason_ff;

endmodule

@@ rtl/core/packet_id_dedup_filter_unit.sv @@
// Packet id deduplication filter.
// req_chan carries one parsed packet per item; rsp_chan returns one verdict
// (drop, verdict_reason) per item, in order. csr_chan writes the UDP port that
// is checked; it is always ready and is meant to be written while idle.
// After reset the block clears its 16384-entry id table, one entry a cycle,
// so req_chan.ready stays low until the whole table is cleared; csr writes are
// taken meanwhile. Each accepted packet reads the table into a register; the
// lookup state then compares, writes an accepted id and registers the verdict,
// and no new packet is taken until that lookup commits.
// When rsp_chan stalls, one verdict is held in the output register and one
// more packet may be accepted; its lookup then waits until the held verdict
// is taken, and req_chan.ready stays low until then.
module packet_id_dedup_filter_unit (
   input logic       clock,
   input logic       reset,
   pdf_req_if.sink   req_chan,
   pdf_rsp_if.source rsp_chan,
   pdf_csr_if.sink   csr_chan
);

   pdf_pkg::ctrl_cmd_type    cmd;
   pdf_pkg::ctrl_status_type status;
   logic                     req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   pdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg_valid         (csr_chan.valid),
      .cfg_port          (csr_chan.match_port),
      .frame_long_enough (req_chan.frame_long_enough),
      .ether_type        (req_chan.ether_type),
      .ip_protocol       (req_chan.ip_protocol),
      .udp_dest_port     (req_chan.udp_dest_port),
      .msg_id            (req_chan.msg_id),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .drop              (rsp_chan.drop),
      .verdict_reason    (rsp_chan.verdict_reason)
   );

endmodule

@@ verif/pdf_verdict_checker.sv @@
module pdf_verdict_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_frame_long_enough,
   input  logic [15:0]                       req_ether_type,
   input  logic [7:0]                        req_ip_protocol,
   input  logic [15:0]                       req_udp_dest_port,
   input  logic signed [pdf_pkg::ID_W-1:0]   req_msg_id,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_drop,
   input  pdf_pkg::reason_type               rsp_verdict_reason,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pdf_pkg::PORT_W-1:0]        csr_match_port,
   output int                                pending,
   output int                                failures
);
   import pdf_pkg::*;

   typedef struct packed {
      logic       drop;
      reason_type reason;
   } verdict_type;

   logic signed [ID_W-1:0] newest_id_per_slot [TABLE_ENTRIES];
   logic                   zero_id_taken;
   logic [PORT_W-1:0]      watched_port;
   verdict_type            expected_verdicts [$];
   int                     mismatch_total = 0;

   function automatic verdict_type judge_packet(
      input logic                   long_ok,
      input logic [15:0]            etype,
      input logic [7:0]             proto,
      input logic [PORT_W-1:0]      dport,
      input logic signed [ID_W-1:0] id
   );
      verdict_type       v;
      logic [SLOT_W-1:0] slot;
      v.drop   = 1'b0;
      v.reason = REASON_UNMATCHED;
      if (long_ok && etype == ETHERTYPE_IPV4 && proto == PROTO_UDP && dport == watched_port) begin
         if (id == '0) begin
            if (zero_id_taken) begin
               v.drop   = 1'b1;
               v.reason = REASON_STALE;
            end else begin
               zero_id_taken = 1'b1;
               v.reason      = REASON_ACCEPTED;
            end
         end else begin
            slot = id[SLOT_W-1:0];
            // Signed compare: a negative id never beats a slot that starts at zero.
            if (newest_id_per_slot[slot] >= id) begin
               v.drop   = 1'b1;
               v.reason = REASON_STALE;
            end else begin
               newest_id_per_slot[slot] = id;
               v.reason                 = REASON_ACCEPTED;
            end
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            newest_id_per_slot[i] = '0;
         end
         zero_id_taken = 1'b0;
         watched_port  = RESET_PORT;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict item with no expectation: drop %0d verdict_reason %0d",
                      rsp_drop, rsp_verdict_reason);
               mismatch_total++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_drop !== want.drop) begin
                  $error("drop: expected %0d, actual %0d", want.drop, rsp_drop);
                  mismatch_total++;
               end
               if (rsp_verdict_reason !== want.reason) begin
                  $error("verdict_reason: expected %0d, actual %0d", want.reason,
                         rsp_verdict_reason);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(judge_packet(req_frame_long_enough, req_ether_type,
                                                     req_ip_protocol, req_udp_dest_port,
                                                     req_msg_id));
         end
         if (csr_valid && csr_ready) begin
            watched_port = csr_match_port;
         end
      end
      pending  <= expected_verdicts.size();
      failures <= mismatch_total;
   end

endmodule

@@ verif/tb_packet_id_dedup_filter_unit.sv @@
module tb_packet_id_dedup_filter_unit;
   import pdf_pkg::*;

   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          PHASE_ITEMS    = 160;
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   pending;
   int   failures;

   logic [PORT_W-1:0]      port_now;
   logic signed [ID_W-1:0] recent_ids [$];

   pdf_req_if req_chan ();
   pdf_rsp_if rsp_chan ();
   pdf_csr_if csr_chan ();

   packet_id_dedup_filter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pdf_verdict_checker verdicts (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_chan.valid),
      .req_ready             (req_chan.ready),
      .req_frame_long_enough (req_chan.frame_long_enough),
      .req_ether_type        (req_chan.ether_type),
      .req_ip_protocol       (req_chan.ip_protocol),
      .req_udp_dest_port     (req_chan.udp_dest_port),
      .req_msg_id            (req_chan.msg_id),
      .rsp_valid             (rsp_chan.valid),
      .rsp_ready             (rsp_chan.ready),
      .rsp_drop              (rsp_chan.drop),
      .rsp_verdict_reason    (rsp_chan.verdict_reason),
      .csr_valid             (csr_chan.valid),
      .csr_ready             (csr_chan.ready),
      .csr_match_port        (csr_chan.match_port),
      .pending               (pending),
      .failures              (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: stalls at random with the current percentage.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_packet(
      input logic                   long_ok,
      input logic [15:0]            etype,
      input logic [7:0]             proto,
      input logic [PORT_W-1:0]      dport,
      input logic signed [ID_W-1:0] id
   );
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.frame_long_enough <= long_ok;
      req_chan.ether_type        <= etype;
      req_chan.ip_protocol       <= proto;
      req_chan.udp_dest_port     <= dport;
      req_chan.msg_id            <= id;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_all_verdicts();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_port(input logic [PORT_W-1:0] value);
      csr_chan.valid      <= 1'b1;
      csr_chan.match_port <= value;
      @(negedge clock);
      while (!csr_chan.ready) @(negedge clock);
      @(posedge clock);
      csr_chan.valid <= 1'b0;
      port_now = value;
   endtask

   // Ids cluster on a few slots so that duplicates and stale ids are common.
   function automatic logic signed [ID_W-1:0] pick_id();
      logic signed [ID_W-1:0] base;
      int                     r;
      r = $urandom_range(99);
      if (recent_ids.size() != 0) begin
         base = recent_ids[$urandom_range(recent_ids.size() - 1)];
      end else begin
         base = 64'sd1;
      end
      if (r < 5) begin
         return '0;
      end else if (r < 20) begin
         return base;
      end else if (r < 45) begin
         if ($urandom_range(1)) begin
            return base + 64'(TABLE_ENTRIES * $urandom_range(1, 3));
         end
         return base - 64'(TABLE_ENTRIES * $urandom_range(1, 3));
      end else if (r < 60) begin
         return {1'b1, 31'($urandom), 32'($urandom)};
      end else if (r < 75) begin
         return {32'($urandom), 32'($urandom)};
      end
      return 64'($urandom_range(0, 15)) + (64'($urandom_range(0, 7)) << SLOT_W);
   endfunction

   task automatic run_phase(input int send_pct, input int recv_pct, input int target);
      int                     matched;
      logic                   long_ok;
      logic [15:0]            etype;
      logic [7:0]             proto;
      logic [PORT_W-1:0]      dport;
      logic signed [ID_W-1:0] id;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      matched       = 0;
      while (matched < target) begin
         long_ok = 1'b1;
         etype   = ETHERTYPE_IPV4;
         proto   = PROTO_UDP;
         dport   = port_now;
         id      = pick_id();
         if ($urandom_range(99) < 80) begin
            matched++;
            recent_ids.push_back(id);
            if (recent_ids.size() > 64) begin
               void'(recent_ids.pop_front());
            end
         end else begin
            case ($urandom_range(4))
               0: long_ok = 1'b0;
               1: etype = 16'($urandom);
               2: proto = 8'($urandom);
               3: dport = 16'($urandom);
               default: begin
                  long_ok = 1'($urandom);
                  etype   = 16'($urandom);
                  proto   = 8'($urandom);
                  dport   = 16'($urandom);
               end
            endcase
         end
         send_packet(long_ok, etype, proto, dport, id);
      end
      req_chan.valid <= 1'b0;
      wait_all_verdicts();
   endtask

   initial begin
      reset                      <= 1'b1;
      req_chan.valid             <= 1'b0;
      req_chan.frame_long_enough <= 1'b0;
      req_chan.ether_type        <= '0;
      req_chan.ip_protocol       <= '0;
      req_chan.udp_dest_port     <= '0;
      req_chan.msg_id            <= '0;
      csr_chan.valid             <= 1'b0;
      csr_chan.match_port        <= '0;
      port_now = RESET_PORT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items run on the port that reset leaves in place.
      send_packet(1'b0, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV6, PROTO_UDP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_TCP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT - 16'd1, 64'sd5);
      send_packet(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, -64'sd1);
      send_packet(1'b0, 16'h0000, 8'h00, 16'h0000, 64'sd0);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd0);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd0);
      send_packet(1'b0, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd0);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd5 + 64'(TABLE_ENTRIES));
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd5);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, -64'sd1);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sh8000_0000_0000_0000);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd16383);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd1);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sd16384);
      send_packet(1'b1, ETHERTYPE_IPV4, PROTO_UDP, RESET_PORT, 64'sh8000_0000_0000_4000);
      req_chan.valid <= 1'b0;
      wait_all_verdicts();

      write_port(16'h0000);
      run_phase(32, 65, PHASE_ITEMS);
      write_port(16'hFFFF);
      run_phase(65, 32, PHASE_ITEMS);
      write_port(16'($urandom_range(1, 65534)));
      run_phase(0, 0, PHASE_ITEMS);

      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
